// ===== hw/rtl/apq_pkg.sv =====
// shared types, codes and default sizes for the array priority queue
`timescale 1ns / 1ps

package apq_pkg;

    // default sizes
    localparam int DEPTH_DEF         = 32;
    localparam int PAYLOAD_BITS_DEF  = 32;
    localparam int PRIORITY_BITS_DEF = 8;

    // command codes
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // per-cycle strobes broadcast from the controller to every cell
    typedef struct packed {
        logic enq;  // write the new entry into the cell at the tail
        logic rem;  // remove the winner, cells at or above it shift down
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/apq_cell.sv =====
// one slot of the queue: stored entry plus a registered stage of the max-search chain
`timescale 1ns / 1ps

module apq_cell #(
    parameter int IDX           = 0,
    parameter int PAYLOAD_BITS  = apq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIORITY_BITS = apq_pkg::PRIORITY_BITS_DEF,
    parameter int IDXW          = 5,
    parameter int OCCW          = 6
) (
    input  logic                     i_clk,
    input  apq_pkg::t_cell_ctrl      i_ctrl,
    input  logic [OCCW-1:0]          i_occ,
    input  logic [IDXW-1:0]          i_best,
    input  logic [PAYLOAD_BITS-1:0]  i_wr_pay,
    input  logic [PRIORITY_BITS-1:0] i_wr_pri,
    // entry of the upper neighbour, taken when the chain closes a gap
    input  logic [PAYLOAD_BITS-1:0]  i_nxt_pay,
    input  logic [PRIORITY_BITS-1:0] i_nxt_pri,
    // best-so-far from the lower neighbour
    input  logic                     i_c_valid,
    input  logic [PRIORITY_BITS-1:0] i_c_pri,
    input  logic [PAYLOAD_BITS-1:0]  i_c_pay,
    input  logic [IDXW-1:0]          i_c_idx,
    // own entry, seen by the lower neighbour
    output logic [PAYLOAD_BITS-1:0]  o_pay,
    output logic [PRIORITY_BITS-1:0] o_pri,
    // registered best-so-far towards the upper neighbour
    output logic                     o_c_valid,
    output logic [PRIORITY_BITS-1:0] o_c_pri,
    output logic [PAYLOAD_BITS-1:0]  o_c_pay,
    output logic [IDXW-1:0]          o_c_idx
);

    localparam logic [OCCW-1:0] MY_OCC = OCCW'(IDX);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    logic [PAYLOAD_BITS-1:0]  r_pay;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic                     r_c_valid;
    logic [PRIORITY_BITS-1:0] r_c_pri;
    logic [PAYLOAD_BITS-1:0]  r_c_pay;
    logic [IDXW-1:0]          r_c_idx;

    logic own_valid;
    logic take_own;

    // slot holds a live entry when it sits below the occupancy
    assign own_valid = (MY_OCC < i_occ);
    // strict compare keeps the older entry on equal priority
    assign take_own  = own_valid && (!i_c_valid || (r_pri > i_c_pri));

    // entry storage: append at the tail or shift down over the removed slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.enq && (i_occ == MY_OCC)) begin
            r_pay <= i_wr_pay;
            r_pri <= i_wr_pri;
        end else if (i_ctrl.rem && (MY_IDX >= i_best)) begin
            r_pay <= i_nxt_pay;
            r_pri <= i_nxt_pri;
        end
    end

    // search stage: pass on the better of the incoming candidate and own entry
    always_ff @(posedge i_clk) begin
        r_c_valid <= take_own || i_c_valid;
        if (take_own) begin
            r_c_pri <= r_pri;
            r_c_pay <= r_pay;
            r_c_idx <= MY_IDX;
        end else begin
            r_c_pri <= i_c_pri;
            r_c_pay <= i_c_pay;
            r_c_idx <= i_c_idx;
        end
    end

    assign o_pay     = r_pay;
    assign o_pri     = r_pri;
    assign o_c_valid = r_c_valid;
    assign o_c_pri   = r_c_pri;
    assign o_c_pay   = r_c_pay;
    assign o_c_idx   = r_c_idx;

endmodule

// ===== hw/rtl/array_priority_queue_core.sv =====
// top level of the array priority queue: controller, cell chain and result register
`timescale 1ns / 1ps

// Bounded priority queue kept as a row of DEPTH cells in arrival order.
// Input channel (i_in_valid / o_in_ready) carries one command per transaction:
// enqueue (payload and priority), dequeue, or clear. Every command gives
// exactly one result transaction on the output channel (o_out_valid /
// i_out_ready) with status, removed payload, entry count and empty/full flags.
// Enqueue, clear, rejected commands and the unused code give a valid result in
// the cycle after acceptance. A dequeue on a non-empty queue first searches:
// the highest priority is found by a candidate travelling one cell per clock
// through the registered search chain; once the last cell holds the winner
// and the result register is free, the controller removes it and shifts the
// later cells down. One command is worked on at a time; the next is taken as
// soon as the result register is free or being read in the same cycle.
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending
// result; stored words are not cleared. When the receiver stalls the result
// waits in the output register and no new command is accepted.
module array_priority_queue_core #(
    parameter int DEPTH         = apq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS  = apq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIORITY_BITS = apq_pkg::PRIORITY_BITS_DEF,
    localparam int OCCW         = $clog2(DEPTH + 1),
    localparam int IDXW         = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [PAYLOAD_BITS-1:0]  i_payload_in,
    input  logic [PRIORITY_BITS-1:0] i_priority_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [PAYLOAD_BITS-1:0]  o_payload_out,
    output logic [OCCW-1:0]          o_entry_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam logic [OCCW-1:0] FULL_CNT = OCCW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [OCCW-1:0]         r_occ, n_occ;
    logic [OCCW-1:0]         r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_status, n_status;
    logic [PAYLOAD_BITS-1:0] r_pay_out, n_pay_out;
    logic                    load_out;

    apq_pkg::t_cell_ctrl     cell_ctrl;
    logic                    accept;
    logic                    out_free;

    // chain wiring, one extra slot per array for the boundary value at one end
    logic [PAYLOAD_BITS-1:0]  cell_pay  [DEPTH+1];
    logic [PRIORITY_BITS-1:0] cell_pri  [DEPTH+1];
    logic                     c_valid   [DEPTH+1];
    logic [PRIORITY_BITS-1:0] c_pri     [DEPTH+1];
    logic [PAYLOAD_BITS-1:0]  c_pay     [DEPTH+1];
    logic [IDXW-1:0]          c_idx     [DEPTH+1];

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // boundary values: nothing above the top cell, no candidate below cell 0
    assign cell_pay[DEPTH] = '0;
    assign cell_pri[DEPTH] = '0;
    assign c_valid[0]      = 1'b0;
    assign c_pri[0]        = '0;
    assign c_pay[0]        = '0;
    assign c_idx[0]        = '0;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        apq_cell #(
            .IDX           (g),
            .PAYLOAD_BITS  (PAYLOAD_BITS),
            .PRIORITY_BITS (PRIORITY_BITS),
            .IDXW          (IDXW),
            .OCCW          (OCCW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (cell_ctrl),
            .i_occ     (r_occ),
            .i_best    (c_idx[DEPTH]),
            .i_wr_pay  (i_payload_in),
            .i_wr_pri  (i_priority_in),
            .i_nxt_pay (cell_pay[g+1]),
            .i_nxt_pri (cell_pri[g+1]),
            .i_c_valid (c_valid[g]),
            .i_c_pri   (c_pri[g]),
            .i_c_pay   (c_pay[g]),
            .i_c_idx   (c_idx[g]),
            .o_pay     (cell_pay[g]),
            .o_pri     (cell_pri[g]),
            .o_c_valid (c_valid[g+1]),
            .o_c_pri   (c_pri[g+1]),
            .o_c_pay   (c_pay[g+1]),
            .o_c_idx   (c_idx[g+1])
        );
    end

    // controller: command decode, search wait and removal
    always_comb begin
        n_state       = r_state;
        n_occ         = r_occ;
        n_cnt         = r_cnt;
        n_status      = r_status;
        n_pay_out     = r_pay_out;
        load_out      = 1'b0;
        cell_ctrl.enq = 1'b0;
        cell_ctrl.rem = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status  = apq_pkg::ST_OK;
                    n_pay_out = '0;
                    load_out  = 1'b1;
                    case (i_cmd)
                        apq_pkg::CMD_ENQ: begin
                            if (r_occ == FULL_CNT) begin
                                n_status = apq_pkg::ST_FULL;
                            end else begin
                                cell_ctrl.enq = 1'b1;
                                n_occ         = r_occ + 1'b1;
                            end
                        end
                        apq_pkg::CMD_DEQ: begin
                            if (r_occ == '0) begin
                                n_status = apq_pkg::ST_EMPTY;
                            end else begin
                                load_out = 1'b0;
                                n_cnt    = FULL_CNT;
                                n_state  = S_SCAN;
                            end
                        end
                        apq_pkg::CMD_CLR: begin
                            n_occ = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else if (out_free) begin
                    // last cell now holds the winner over the whole row
                    cell_ctrl.rem = 1'b1;
                    n_occ         = r_occ - 1'b1;
                    n_status      = apq_pkg::ST_OK;
                    n_pay_out     = c_pay[DEPTH];
                    load_out      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_pay_out <= n_pay_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload_out = r_pay_out;
    assign o_entry_count = r_occ;
    assign o_is_empty    = (r_occ == '0);
    assign o_is_full     = (r_occ == FULL_CNT);

endmodule

// ===== dv/array_priority_queue_core_tb.sv =====
// self-checking testbench for the array priority queue core
`timescale 1ns / 1ps

module array_priority_queue_core_tb;

    localparam int DEPTH         = apq_pkg::DEPTH_DEF;
    localparam int PAYLOAD_BITS  = apq_pkg::PAYLOAD_BITS_DEF;
    localparam int PRIORITY_BITS = apq_pkg::PRIORITY_BITS_DEF;
    localparam int OCCW          = $clog2(DEPTH + 1);

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int IDLE_PCT     = 19;

    typedef logic [PAYLOAD_BITS-1:0]  t_payload;
    typedef logic [PRIORITY_BITS-1:0] t_prio;

    typedef struct packed {
        logic [1:0]      status;
        t_payload        payload;
        logic [OCCW-1:0] count;
        logic            empty;
        logic            full;
    } t_pq_result;

    // queue contents in arrival order and the results still owed by the block
    class pq_result_checker;
        t_payload   entry_payloads[$];
        t_prio      entry_prios[$];
        t_pq_result owed_results[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        // work out the result of one accepted command and update the queue
        function void note_command(logic [1:0] c, t_payload p, t_prio r);
            t_pq_result res;
            int         best;
            res = '0;
            res.status = apq_pkg::ST_OK;
            case (c)
                apq_pkg::CMD_ENQ: begin
                    if (entry_prios.size() >= DEPTH) begin
                        res.status = apq_pkg::ST_FULL;
                    end else begin
                        entry_payloads.push_back(p);
                        entry_prios.push_back(r);
                    end
                end
                apq_pkg::CMD_DEQ: begin
                    if (entry_prios.size() == 0) begin
                        res.status = apq_pkg::ST_EMPTY;
                    end else begin
                        // strict compare so the oldest of equal priorities wins
                        best = 0;
                        for (int i = 1; i < entry_prios.size(); i++) begin
                            if (entry_prios[i] > entry_prios[best]) best = i;
                        end
                        res.payload = entry_payloads[best];
                        entry_payloads.delete(best);
                        entry_prios.delete(best);
                    end
                end
                apq_pkg::CMD_CLR: begin
                    entry_payloads.delete();
                    entry_prios.delete();
                end
                default: ;
            endcase
            res.count = OCCW'(entry_prios.size());
            res.empty = (entry_prios.size() == 0);
            res.full  = (entry_prios.size() >= DEPTH);
            owed_results.push_back(res);
        endfunction

        // compare one result transaction with the oldest owed result
        function void check_result(t_pq_result got);
            t_pq_result want;
            if (owed_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.payload !== want.payload) begin
                $error("payload_out: expected %0h, got %0h", want.payload, got.payload);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $error("is_empty: expected %0b, got %0b", want.empty, got.empty);
                errors++;
            end
            if (got.full !== want.full) begin
                $error("is_full: expected %0b, got %0b", want.full, got.full);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          cmd_in = apq_pkg::CMD_ENQ;
    t_payload            payload_in = '0;
    t_prio               prio_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status_out;
    t_payload            payload_out;
    logic [OCCW-1:0]     count_out;
    logic                empty_out;
    logic                full_out;

    bit                  in_idle_en = 1'b1;
    bit                  out_idle_en = 1'b1;
    bit                  hold_req = 1'b0;
    int                  sent = 0;
    pq_result_checker    sb;

    array_priority_queue_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_cmd         (cmd_in),
        .i_payload_in  (payload_in),
        .i_priority_in (prio_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status_out),
        .o_payload_out (payload_out),
        .o_entry_count (count_out),
        .o_is_empty    (empty_out),
        .o_is_full     (full_out)
    );

    // 4 ns clock
    initial begin
        forever #2 clk = ~clk;
    end

    // offer one command from a falling edge and hold it until accepted
    task automatic send_cmd(input logic [1:0] c, input t_payload p, input t_prio r);
        while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd_in     <= c;
        payload_in <= p;
        prio_in    <= r;
        do @(posedge clk); while (!in_ready);
        sb.note_command(c, p, r);
        sent++;
        @(negedge clk);
    endtask

    // sender stands back until every owed result has come out
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (sb.owed() != 0) @(negedge clk);
    endtask

    // priorities skewed towards ties and the extremes
    function automatic t_prio rand_prio();
        case ($urandom_range(9))
            5, 6, 7: return t_prio'($urandom_range(3));
            8:       return '0;
            9:       return '1;
            default: return t_prio'($urandom_range(255));
        endcase
    endfunction

    // pick a command for the current mix: 0 filling, 1 draining, 2 balanced
    function automatic logic [1:0] rand_cmd(int mix);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return apq_pkg::CMD_CLR;
        if (roll < 4) return CMD_UNUSED;
        case (mix)
            0:       return (roll < 85) ? apq_pkg::CMD_ENQ : apq_pkg::CMD_DEQ;
            1:       return (roll < 25) ? apq_pkg::CMD_ENQ : apq_pkg::CMD_DEQ;
            default: return (roll < 54) ? apq_pkg::CMD_ENQ : apq_pkg::CMD_DEQ;
        endcase
    endfunction

    // receiver: random back-pressure plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= !(out_idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // check every result transaction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result('{status_out, payload_out, count_out, empty_out, full_out});
        end
    end

    // give up when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("array_priority_queue_core_tb NOT OK");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int mix;
        int span;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, extremes, ties, unused code and clear
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_CLR, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(CMD_UNUSED,       32'hFFFF_FFFF, 8'hFF);
        send_cmd(apq_pkg::CMD_ENQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(apq_pkg::CMD_ENQ, 32'h5555_AAAA, 8'h80);
        send_cmd(apq_pkg::CMD_ENQ, 32'hAAAA_5555, 8'hFF);
        send_cmd(apq_pkg::CMD_ENQ, 32'h0000_FFFF, 8'h7F);
        send_cmd(CMD_UNUSED,       32'h1234_5678, 8'h55);
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_ENQ, 32'h1234_5678, 8'h00);
        send_cmd(apq_pkg::CMD_DEQ, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_ENQ, 32'hFEDC_BA98, 8'h01);
        send_cmd(apq_pkg::CMD_ENQ, 32'h8000_0001, 8'hAA);
        send_cmd(apq_pkg::CMD_CLR, 32'h0000_0000, 8'h00);
        send_cmd(apq_pkg::CMD_DEQ, 32'h0000_0000, 8'h00);

        // no idling: fill past full with a long receiver hold-off, then drain past empty
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        for (int i = 0; i < DEPTH + 4; i++) begin
            if (i == 8) hold_req = 1'b1;
            send_cmd(apq_pkg::CMD_ENQ, t_payload'($urandom), rand_prio());
        end
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_cmd(apq_pkg::CMD_DEQ, t_payload'($urandom), rand_prio());
        end
        wait_all_results();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;

        // random phases that swing the queue between full and empty
        while (sent < RANDOM_ITEMS) begin
            mix  = $urandom_range(2);
            span = $urandom_range(10, 40);
            for (int i = 0; i < span; i++) begin
                send_cmd(rand_cmd(mix), t_payload'($urandom), rand_prio());
            end
            if ($urandom_range(7) == 0) wait_all_results();
        end

        // let the last results drain, then allow for a full search
        wait_all_results();
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("array_priority_queue_core_tb OK");
        end else begin
            $display("array_priority_queue_core_tb NOT OK");
        end
        $finish;
    end

endmodule
